>>> hdl/hbe_pkg.sv
// Package: item types and character constants for the HTTP body extractor.
`timescale 1ns / 1ps

package hbe_pkg;

  // Input item: one message byte and its end marker
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } msg_item_t;

  // Result item: body byte and end-of-message status
  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] parse_status;
  } res_item_t;

  // End-of-message status codes
  localparam logic [1:0] STATUS_BODY       = 2'd0;
  localparam logic [1:0] STATUS_NO_HDR_END = 2'd1;
  localparam logic [1:0] STATUS_NO_LENGTH  = 2'd2;

  // Characters
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Header name matched at a line start
  localparam int unsigned PREFIX_LEN = 15;
  localparam logic [3:0]  PREFIX_LAST = 4'(PREFIX_LEN - 1);

  // Character of "Content-Length:" at a given position
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/http_body_extractor.sv
// Top level: streaming extractor of a Content-Length framed HTTP message body.
`timescale 1ns / 1ps
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  msg     | msg_valid / msg_ready  | msg_item_t: msg_byte, msg_last
//  res     | res_valid / res_ready  | res_item_t: body_byte, byte_valid,
//          |                        |   end_of_message, parse_status
//
//  One item per cycle: each accepted byte updates the header matchers, the
//  length accumulator and the body counter; a result, if any, sits in the
//  result register on the next cycle.
//  The result register is the only stall point: msg_ready is low only while a
//  result is held and res_ready is low.
//  Reset (rst, synchronous) returns to the header phase; the final byte of a
//  message does the same after producing its end result.
module http_body_extractor
  import hbe_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_item_t msg,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  // Parse phase codes
  localparam logic PHASE_HEADER = 1'b0;
  localparam logic PHASE_BODY   = 1'b1;

  // Length field codes
  localparam logic [1:0] LEN_IDLE   = 2'd0;
  localparam logic [1:0] LEN_BLANKS = 2'd1;
  localparam logic [1:0] LEN_DIGITS = 2'd2;
  localparam logic [1:0] LEN_DONE   = 2'd3;

  localparam int unsigned WIDE_BITS = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic                   phase, phase_next;
  logic                   at_line_start, at_line_start_next;
  logic [3:0]             prefix_idx, prefix_idx_next;
  logic [1:0]             len_field, len_field_next;
  logic [1:0]             crlf_cnt, crlf_cnt_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic [LENGTH_BITS-1:0] body_sent, body_sent_next;

  logic                   accept;
  logic                   send_byte;
  logic                   has_result;
  logic                   line_end;
  logic                   is_digit;
  logic                   is_blank;
  logic [3:0]             digit;
  logic [WIDE_BITS-1:0]   len_wide;
  logic [LENGTH_BITS-1:0] len_acc;
  logic [3:0]             prefix_step;
  res_item_t              res_next;

  assign msg_ready = !res_valid || res_ready;
  assign accept    = msg_valid && msg_ready;

  // Classify the byte and form the next length value
  assign is_digit = msg.msg_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_blank = msg.msg_byte inside {CHAR_SPACE, CHAR_TAB};
  assign digit    = msg.msg_byte[3:0];
  assign len_wide = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1)
                  + WIDE_BITS'(digit);
  assign len_acc  = (len_wide[WIDE_BITS-1:LENGTH_BITS] != 4'd0)
                  ? LEN_MAX : len_wide[LENGTH_BITS-1:0];

  // Decide the next state for one byte
  always_comb begin
    phase_next         = phase;
    at_line_start_next = at_line_start;
    prefix_idx_next    = prefix_idx;
    len_field_next     = len_field;
    crlf_cnt_next      = crlf_cnt;
    length_value_next  = length_value;
    body_sent_next     = body_sent;
    send_byte          = 1'b0;
    line_end           = (msg.msg_byte == CHAR_LF) && (crlf_cnt == 2'd1 || crlf_cnt == 2'd3);
    prefix_step        = 4'd0;

    if (phase == PHASE_BODY) begin
      // Pass body bytes up to the length
      if (body_sent < length_value) begin
        send_byte      = 1'b1;
        body_sent_next = body_sent + LENGTH_BITS'(1);
      end
    end else if (msg.msg_byte == CHAR_LF && crlf_cnt == 2'd3) begin
      // Blank line: enter the body
      phase_next     = PHASE_BODY;
      body_sent_next = '0;
      crlf_cnt_next  = 2'd0;
    end else begin
      // Track CR LF CR LF
      if (msg.msg_byte == CHAR_CR) begin
        crlf_cnt_next = (crlf_cnt == 2'd2) ? 2'd3 : 2'd1;
      end else if (msg.msg_byte == CHAR_LF && crlf_cnt == 2'd1) begin
        crlf_cnt_next = 2'd2;
      end else begin
        crlf_cnt_next = 2'd0;
      end

      case (len_field)
        LEN_BLANKS: begin
          if (is_digit) begin
            length_value_next = LENGTH_BITS'(digit);
            len_field_next    = LEN_DIGITS;
          end else if (!is_blank) begin
            // Sign or other character: length is zero
            length_value_next = '0;
            len_field_next    = LEN_DONE;
          end
        end
        LEN_DIGITS: begin
          if (is_digit) begin
            length_value_next = len_acc;
          end else begin
            len_field_next = LEN_DONE;
          end
        end
        LEN_IDLE: begin
          // Match the header name
          if (prefix_idx != 4'd0) begin
            prefix_step = (msg.msg_byte == prefix_char(prefix_idx))
                        ? prefix_idx + 4'd1 : 4'd0;
          end else if (at_line_start && msg.msg_byte == prefix_char(4'd0)) begin
            prefix_step = 4'd1;
          end
          if (prefix_idx == PREFIX_LAST && prefix_step != 4'd0) begin
            prefix_idx_next   = 4'd0;
            len_field_next    = LEN_BLANKS;
            length_value_next = '0;
          end else begin
            prefix_idx_next = prefix_step;
          end
        end
        default: begin
          // Field finished: ignore the rest of the line
        end
      endcase

      if (line_end) begin
        at_line_start_next = 1'b1;
        len_field_next     = LEN_IDLE;
        prefix_idx_next    = 4'd0;
      end else begin
        at_line_start_next = 1'b0;
      end
    end
  end

  // Build the result
  assign has_result = send_byte || msg.msg_last;

  always_comb begin
    res_next.body_byte      = send_byte ? msg.msg_byte : 8'd0;
    res_next.byte_valid     = send_byte;
    res_next.end_of_message = msg.msg_last;
    res_next.parse_status   = STATUS_BODY;
    if (msg.msg_last) begin
      if (phase_next != PHASE_BODY) begin
        res_next.parse_status = STATUS_NO_HDR_END;
      end else if (length_value_next == '0) begin
        res_next.parse_status = STATUS_NO_LENGTH;
      end
    end
  end

  // Advance parser state; drop back to reset after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && msg.msg_last)) begin
      phase         <= PHASE_HEADER;
      at_line_start <= 1'b1;
      prefix_idx    <= 4'd0;
      len_field     <= LEN_IDLE;
      crlf_cnt      <= 2'd0;
      length_value  <= '0;
      body_sent     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      at_line_start <= at_line_start_next;
      prefix_idx    <= prefix_idx_next;
      len_field     <= len_field_next;
      crlf_cnt      <= crlf_cnt_next;
      length_value  <= length_value_next;
      body_sent     <= body_sent_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && has_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      res <= res_next;
    end
  end

  // Every result carries a body byte or ends a message
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.byte_valid || res.end_of_message))
    else $error("result with neither body byte nor end marker");

  // Status is only reported on the end result
  a_status_on_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.end_of_message) |-> (res.parse_status == STATUS_BODY))
    else $error("status set on a non-final result");

  // Body count never passes the length
  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    body_sent <= length_value)
    else $error("body count beyond length");

  // The final byte returns the parser to the header phase
  a_msg_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && msg.msg_last) |=> (phase == PHASE_HEADER && body_sent == '0
                                  && length_value == '0))
    else $error("parser not restarted after final byte");

endmodule
